### rtl/pitl_pkg.sv
// Package with shared types, constants and the face table of the tetrahedron locator.
`timescale 1ns / 1ps
package pitl_pkg;

    localparam int unsigned MAX_CELLS_DEF  = 1024;
    localparam int unsigned COORD_BITS_DEF = 16;
    localparam int unsigned SLOT_W         = 10;
    localparam int unsigned CORNER_W       = 2;
    localparam int unsigned IN_COORD_W     = 16;
    localparam int unsigned ID_W           = 32;
    localparam int unsigned KEY_W          = 54;
    localparam int unsigned COUNT_W        = 11;
    localparam int unsigned CFG_ADDR_W     = 4;
    localparam int unsigned CFG_DATA_W     = 64;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam logic CFG_REG_TOLERANCE = 1'b0;
    localparam logic CFG_REG_COUNT     = 1'b1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic {
        OP_LOAD,
        OP_QUERY
    } op_t;

    typedef struct packed {
        logic                          cmd;
        logic [SLOT_W-1:0]             slot;
        logic [CORNER_W-1:0]           corner;
        logic signed [IN_COORD_W-1:0]  x;
        logic signed [IN_COORD_W-1:0]  y;
        logic signed [IN_COORD_W-1:0]  z;
        logic [ID_W-1:0]               global_id;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] cell_slot;
        logic [ID_W-1:0]   cell_global_id;
        logic [KEY_W-1:0]  miss_key;
    } out_item_t;

    typedef struct packed {
        op_t      op;
        in_item_t item;
    } queue_entry_t;

    // Corners a, b, d and the opposite corner o of each face.
    function automatic logic [CORNER_W-1:0] face_corner(input logic [1:0] f,
                                                        input logic [1:0] k);
        logic [7:0] row;
        begin
            unique case (f)
                2'd0:    row = {2'd3, 2'd1, 2'd2, 2'd0};
                2'd1:    row = {2'd2, 2'd3, 2'd1, 2'd0};
                2'd2:    row = {2'd1, 2'd2, 2'd3, 2'd0};
                default: row = {2'd0, 2'd3, 2'd2, 2'd1};
            endcase
            face_corner = row[k*2 +: 2];
        end
    endfunction

endpackage

### rtl/pitl_front.sv
// Front part: classifies requests and holds them in a short queue for the back part.
`timescale 1ns / 1ps
module pitl_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pitl_pkg::in_item_t    in_data,
    output logic                  q_valid,
    output pitl_pkg::queue_entry_t q_head,
    input  logic                  q_take
);
    import pitl_pkg::*;

    queue_entry_t entry_reg [QUEUE_DEPTH];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   fill_reg, fill_next;
    logic         push;
    queue_entry_t new_entry;

    assign in_stall = (fill_reg == 2'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_head   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_entry.item = in_data;
        new_entry.op   = (in_data.cmd == CMD_QUERY) ? OP_QUERY : OP_LOAD;
        wr_ptr_next    = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next    = q_take ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next      = fill_reg + 2'(push) - 2'(q_take);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### rtl/pitl_back.sv
// Back part: corner and id tables, the pipelined plane test and the best-cell search.
`timescale 1ns / 1ps
module pitl_back
#(
    parameter int unsigned MAX_CELLS  = pitl_pkg::MAX_CELLS_DEF,
    parameter int unsigned COORD_BITS = pitl_pkg::COORD_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  pitl_pkg::queue_entry_t q_head,
    output logic                   q_take,
    input  logic [pitl_pkg::KEY_W-1:0]   tolerance,
    input  logic [pitl_pkg::COUNT_W-1:0] element_count,
    output logic                   out_valid,
    input  logic                   out_stall,
    output pitl_pkg::out_item_t    out_data
);
    import pitl_pkg::*;

    localparam int unsigned IDX_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_CELLS + 1);
    localparam int unsigned SLOT_X = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int unsigned CB     = COORD_BITS;
    localparam int unsigned E      = CB + 1;
    localparam int unsigned P      = 2 * E;
    localparam int unsigned N      = P + 1;
    localparam int unsigned D      = N + E;
    localparam int unsigned S      = D + 2;
    localparam int unsigned CMP_W  = ((S > KEY_W) ? S : KEY_W) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t state_reg;

    // One memory per corner so all four corners of a cell are read together.
    logic [3*CB-1:0] vtx_mem0 [MAX_CELLS];
    logic [3*CB-1:0] vtx_mem1 [MAX_CELLS];
    logic [3*CB-1:0] vtx_mem2 [MAX_CELLS];
    logic [3*CB-1:0] vtx_mem3 [MAX_CELLS];
    logic [ID_W-1:0] id_mem   [MAX_CELLS];

    logic              take_load, take_query, issue, scan_last, pipe_busy;
    logic [SLOT_X-1:0] slot_ext;
    logic [IDX_W-1:0]  wr_idx;
    logic              slot_ok;
    logic [3*CB-1:0]   wr_vtx;
    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_end_reg;
    logic signed [CB-1:0] qx_reg, qy_reg, qz_reg;

    // Stage 1: table read.
    logic              v1_reg;
    logic [CNT_W-1:0]  s1_reg;
    logic [3*CB-1:0]   rd_vtx_reg [4];
    logic [ID_W-1:0]   id1_reg;
    // Stage 2: edges.
    logic              v2_reg;
    logic [CNT_W-1:0]  s2_reg;
    logic [ID_W-1:0]   id2_reg;
    logic signed [E-1:0] e1_reg [4][3];
    logic signed [E-1:0] e2_reg [4][3];
    logic signed [E-1:0] to2_reg [4][3];
    logic signed [E-1:0] tq2_reg [4][3];
    // Stage 3: cross product terms.
    logic              v3_reg;
    logic [CNT_W-1:0]  s3_reg;
    logic [ID_W-1:0]   id3_reg;
    logic signed [P-1:0] pa_reg [4][3];
    logic signed [P-1:0] pb_reg [4][3];
    logic signed [E-1:0] to3_reg [4][3];
    logic signed [E-1:0] tq3_reg [4][3];
    // Stage 4: dot product terms.
    logic              v4_reg;
    logic [CNT_W-1:0]  s4_reg;
    logic [ID_W-1:0]   id4_reg;
    logic signed [D-1:0] mto_reg [4][3];
    logic signed [D-1:0] mtq_reg [4][3];
    // Stage 5: cell miss.
    logic              v5_reg;
    logic [CNT_W-1:0]  s5_reg;
    logic [ID_W-1:0]   id5_reg;
    logic signed [S-1:0] miss_reg;

    logic              found_reg;
    logic [CNT_W-1:0]  best_slot_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic [KEY_W-1:0]  best_key_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic signed [E-1:0] e1_next [4][3];
    logic signed [E-1:0] e2_next [4][3];
    logic signed [E-1:0] to_next [4][3];
    logic signed [E-1:0] tq_next [4][3];
    logic signed [P-1:0] pa_next [4][3];
    logic signed [P-1:0] pb_next [4][3];
    logic signed [D-1:0] mto_next [4][3];
    logic signed [D-1:0] mtq_next [4][3];
    logic signed [S-1:0] miss_next;
    logic              cand;
    logic [KEY_W-1:0]  key;
    logic              better;

    assign q_take     = (state_reg == ST_IDLE) && q_valid &&
                        ((q_head.op == OP_LOAD) || !out_valid_reg);
    assign take_load  = q_take && (q_head.op == OP_LOAD);
    assign take_query = q_take && (q_head.op == OP_QUERY);
    assign slot_ext   = SLOT_X'(q_head.item.slot);
    assign wr_idx     = slot_ext[IDX_W-1:0];
    assign slot_ok    = (32'(q_head.item.slot) < 32'(MAX_CELLS));
    assign wr_vtx     = {q_head.item.z[CB-1:0], q_head.item.y[CB-1:0],
                         q_head.item.x[CB-1:0]};
    assign limit      = (32'(element_count) > 32'(MAX_CELLS)) ? CNT_W'(MAX_CELLS)
                                                              : CNT_W'(element_count);
    assign issue      = (state_reg == ST_SCAN);
    assign scan_last  = (scan_cnt_reg + CNT_W'(1) == scan_end_reg);
    assign pipe_busy  = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (take_load && slot_ok)
        begin
            unique case (q_head.item.corner)
                2'd0:    vtx_mem0[wr_idx] <= wr_vtx;
                2'd1:    vtx_mem1[wr_idx] <= wr_vtx;
                2'd2:    vtx_mem2[wr_idx] <= wr_vtx;
                default: vtx_mem3[wr_idx] <= wr_vtx;
            endcase
            id_mem[wr_idx] <= q_head.item.global_id;
        end
        if (issue)
        begin
            rd_vtx_reg[0] <= vtx_mem0[scan_cnt_reg[IDX_W-1:0]];
            rd_vtx_reg[1] <= vtx_mem1[scan_cnt_reg[IDX_W-1:0]];
            rd_vtx_reg[2] <= vtx_mem2[scan_cnt_reg[IDX_W-1:0]];
            rd_vtx_reg[3] <= vtx_mem3[scan_cnt_reg[IDX_W-1:0]];
            id1_reg       <= id_mem[scan_cnt_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        logic signed [CB-1:0] ca, cb, cd, co, cq;
        for (int f = 0; f < 4; f++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ca = rd_vtx_reg[face_corner(2'(f), 2'd0)][i*CB +: CB];
                cb = rd_vtx_reg[face_corner(2'(f), 2'd1)][i*CB +: CB];
                cd = rd_vtx_reg[face_corner(2'(f), 2'd2)][i*CB +: CB];
                co = rd_vtx_reg[face_corner(2'(f), 2'd3)][i*CB +: CB];
                cq = (i == 0) ? qx_reg : ((i == 1) ? qy_reg : qz_reg);
                e1_next[f][i] = E'(cb) - E'(ca);
                e2_next[f][i] = E'(cd) - E'(ca);
                to_next[f][i] = E'(co) - E'(ca);
                tq_next[f][i] = E'(cq) - E'(ca);
            end
        end
    end

    always_comb
    begin
        for (int f = 0; f < 4; f++)
        begin
            // n = e1 x e2, each component as pa - pb.
            pa_next[f][0] = P'(e1_reg[f][1]) * P'(e2_reg[f][2]);
            pb_next[f][0] = P'(e1_reg[f][2]) * P'(e2_reg[f][1]);
            pa_next[f][1] = P'(e1_reg[f][2]) * P'(e2_reg[f][0]);
            pb_next[f][1] = P'(e1_reg[f][0]) * P'(e2_reg[f][2]);
            pa_next[f][2] = P'(e1_reg[f][0]) * P'(e2_reg[f][1]);
            pb_next[f][2] = P'(e1_reg[f][1]) * P'(e2_reg[f][0]);
        end
    end

    always_comb
    begin
        logic signed [N-1:0] n;
        for (int f = 0; f < 4; f++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n = N'(pa_reg[f][i]) - N'(pb_reg[f][i]);
                mto_next[f][i] = D'(n) * D'(to3_reg[f][i]);
                mtq_next[f][i] = D'(n) * D'(tq3_reg[f][i]);
            end
        end
    end

    always_comb
    begin
        logic signed [S-1:0] side, val;
        miss_next = '0;
        for (int f = 0; f < 4; f++)
        begin
            side = S'(mto_reg[f][0]) + S'(mto_reg[f][1]) + S'(mto_reg[f][2]);
            val  = S'(mtq_reg[f][0]) + S'(mtq_reg[f][1]) + S'(mtq_reg[f][2]);
            if (side > 0)
            begin
                val = -val;
            end
            if (f == 0 || val > miss_next)
            begin
                miss_next = val;
            end
        end
    end

    always_comb
    begin
        logic signed [CMP_W-1:0] miss_w, tol_w;
        miss_w = CMP_W'(miss_reg);
        tol_w  = $signed({1'b0, (CMP_W-1)'(tolerance)});
        cand   = v5_reg && (miss_w <= tol_w);
        key    = (miss_reg <= 0) ? '0 : KEY_W'(miss_w);
        better = !found_reg || (key < best_key_reg) ||
                 ((key == best_key_reg) && (id5_reg < best_id_reg));
    end

    always_ff @(posedge clk)
    begin
        if (take_query)
        begin
            qx_reg <= q_head.item.x[CB-1:0];
            qy_reg <= q_head.item.y[CB-1:0];
            qz_reg <= q_head.item.z[CB-1:0];
        end
        s1_reg  <= scan_cnt_reg;
        s2_reg  <= s1_reg;
        id2_reg <= id1_reg;
        e1_reg  <= e1_next;
        e2_reg  <= e2_next;
        to2_reg <= to_next;
        tq2_reg <= tq_next;
        s3_reg  <= s2_reg;
        id3_reg <= id2_reg;
        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
        to3_reg <= to2_reg;
        tq3_reg <= tq2_reg;
        s4_reg  <= s3_reg;
        id4_reg <= id3_reg;
        mto_reg <= mto_next;
        mtq_reg <= mtq_next;
        s5_reg  <= s4_reg;
        id5_reg <= id4_reg;
        miss_reg <= miss_next;
        if (take_query)
        begin
            best_slot_reg <= '0;
            best_id_reg   <= '0;
            best_key_reg  <= '0;
        end
        else if (cand && better)
        begin
            best_slot_reg <= s5_reg;
            best_id_reg   <= id5_reg;
            best_key_reg  <= key;
        end
        if ((state_reg == ST_DRAIN) && !pipe_busy)
        begin
            out_data_reg.found          <= found_reg;
            out_data_reg.cell_slot      <= SLOT_W'(best_slot_reg);
            out_data_reg.cell_global_id <= best_id_reg;
            out_data_reg.miss_key       <= best_key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            scan_end_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (take_query)
            begin
                found_reg <= 1'b0;
            end
            else if (cand)
            begin
                found_reg <= 1'b1;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take_query)
                    begin
                        scan_cnt_reg <= '0;
                        scan_end_reg <= limit;
                        state_reg    <= (limit == '0) ? ST_DRAIN : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                    if (scan_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                default:
                begin
                    if (!pipe_busy)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

### rtl/point_in_tetrahedron_locator_unit.sv
// Top level of the point-in-tetrahedron locator: configuration registers and the two parts.
//
// A load request writes one corner and the cell id. A query request scans slots 0 to
// min(element_count, MAX_CELLS)-1, one cell per cycle through the pipelined plane test
// fed by one table read per cycle, and the next query starts once its result has left
// the output register. Requests queue in a two-entry buffer in front of the scan engine.
// Registers lie at byte address 0 (tolerance) and 8 (element_count) on the 64-bit port.
`timescale 1ns / 1ps
module point_in_tetrahedron_locator_unit
#(
    parameter int unsigned MAX_CELLS  = pitl_pkg::MAX_CELLS_DEF,
    parameter int unsigned COORD_BITS = pitl_pkg::COORD_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  pitl_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output pitl_pkg::out_item_t             out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pitl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pitl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pitl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import pitl_pkg::*;

    logic [KEY_W-1:0]   tolerance_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               cfg_wr;
    logic               q_valid, q_take;
    queue_entry_t       q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[3] == CFG_REG_COUNT) ? CFG_DATA_W'(count_reg)
                                                : CFG_DATA_W'(tolerance_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= '0;
            count_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3])
                CFG_REG_TOLERANCE: tolerance_reg <= pwdata[KEY_W-1:0];
                default:           count_reg     <= pwdata[COUNT_W-1:0];
            endcase
        end
    end

    pitl_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_take   (q_take)
    );

    pitl_back
    #(
        .MAX_CELLS  (MAX_CELLS),
        .COORD_BITS (COORD_BITS)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_take        (q_take),
        .tolerance     (tolerance_reg),
        .element_count (count_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data)
    );

endmodule

### rtl/pitl_checker.sv
// Port-level checker for the locator and the bind that attaches it.
`timescale 1ns / 1ps
module pitl_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input pitl_pkg::out_item_t out_data,
    input logic                pready
);
    import pitl_pkg::*;

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A miss reports all-zero fields.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> (out_data.miss_key == '0) &&
        (out_data.cell_slot == '0) && (out_data.cell_global_id == '0))
        else $error("empty result carries data");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("configuration port not ready");

endmodule

bind point_in_tetrahedron_locator_unit pitl_checker u_pitl_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .pready    (pready)
);

### sim/pitl_scoreboard.sv
// Checker for the tetrahedron locator: tracks cell table and registers, predicts and compares results.
`timescale 1ns / 1ps
module pitl_scoreboard
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  pitl_pkg::in_item_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  pitl_pkg::out_item_t             out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [pitl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pitl_pkg::CFG_DATA_W-1:0] pwdata,
    output int                              fail_count,
    output int                              waiting
);
    import pitl_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] ADDR_TOL   = {CFG_REG_TOLERANCE, 3'b000};
    localparam logic [CFG_ADDR_W-1:0] ADDR_COUNT = {CFG_REG_COUNT, 3'b000};
    localparam int CELLS = 1024;
    // Corners a, b, d and the opposite corner of each face.
    localparam int FACE_TBL [4][4] = '{'{0, 2, 1, 3}, '{0, 1, 3, 2},
                                       '{0, 3, 2, 1}, '{1, 2, 3, 0}};

    int              vx [4*CELLS];
    int              vy [4*CELLS];
    int              vz [4*CELLS];
    logic [ID_W-1:0] cell_ids [CELLS];
    logic [KEY_W-1:0]   tol_reg;
    logic [COUNT_W-1:0] count_reg;
    out_item_t          located_q [$];

    function automatic longint worst_plane(int c, int qx, int qy, int qz);
        longint worst;
        longint e1 [3];
        longint e2 [3];
        longint to [3];
        longint tq [3];
        longint n [3];
        longint side;
        longint val;
        int a;
        int b;
        int d;
        int o;
        worst = 64'sh8000_0000_0000_0000;
        for (int f = 0; f < 4; f++)
        begin
            a = c * 4 + FACE_TBL[f][0];
            b = c * 4 + FACE_TBL[f][1];
            d = c * 4 + FACE_TBL[f][2];
            o = c * 4 + FACE_TBL[f][3];
            e1 = '{vx[b] - vx[a], vy[b] - vy[a], vz[b] - vz[a]};
            e2 = '{vx[d] - vx[a], vy[d] - vy[a], vz[d] - vz[a]};
            to = '{vx[o] - vx[a], vy[o] - vy[a], vz[o] - vz[a]};
            tq = '{qx - vx[a], qy - vy[a], qz - vz[a]};
            n[0] = e1[1] * e2[2] - e1[2] * e2[1];
            n[1] = e1[2] * e2[0] - e1[0] * e2[2];
            n[2] = e1[0] * e2[1] - e1[1] * e2[0];
            side = n[0] * to[0] + n[1] * to[1] + n[2] * to[2];
            val  = n[0] * tq[0] + n[1] * tq[1] + n[2] * tq[2];
            // Flip so that positive always means outside the face.
            if (side > 0)
                val = -val;
            if (val > worst)
                worst = val;
        end
        return worst;
    endfunction

    function automatic out_item_t locate_point(int qx, int qy, int qz);
        out_item_t best;
        longint miss;
        longint tol;
        logic [KEY_W-1:0] key;
        int lim;
        best = '0;
        tol = longint'(tol_reg);
        lim = (count_reg > CELLS) ? CELLS : int'(count_reg);
        for (int c = 0; c < lim; c++)
        begin
            miss = worst_plane(c, qx, qy, qz);
            if (miss <= tol)
            begin
                key = (miss <= 0) ? '0 : KEY_W'(miss);
                if (!best.found || key < best.miss_key ||
                    (key == best.miss_key && cell_ids[c] < best.cell_global_id))
                begin
                    best.found = 1'b1;
                    best.cell_slot = SLOT_W'(c);
                    best.cell_global_id = cell_ids[c];
                    best.miss_key = key;
                end
            end
        end
        return best;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        int idx;
        if (!rst_n)
        begin
            tol_reg = '0;
            count_reg = '0;
            located_q.delete();
            fail_count = 0;
            waiting = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_TOL)
                    tol_reg = pwdata[KEY_W-1:0];
                else if (paddr == ADDR_COUNT)
                    count_reg = pwdata[COUNT_W-1:0];
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.cmd == CMD_LOAD)
                begin
                    idx = int'(in_data.slot) * 4 + int'(in_data.corner);
                    vx[idx] = int'($signed(in_data.x));
                    vy[idx] = int'($signed(in_data.y));
                    vz[idx] = int'($signed(in_data.z));
                    cell_ids[in_data.slot] = in_data.global_id;
                end
                else
                    located_q.push_back(locate_point(int'($signed(in_data.x)),
                                                     int'($signed(in_data.y)),
                                                     int'($signed(in_data.z))));
            end
            if (out_valid && !out_stall)
            begin
                if (located_q.size() == 0)
                begin
                    $display("%0t: unexpected result found=%0d slot=%0d id=%0h key=%0h",
                             $time, out_data.found, out_data.cell_slot,
                             out_data.cell_global_id, out_data.miss_key);
                    fail_count++;
                end
                else
                begin
                    e = located_q.pop_front();
                    if (out_data.found !== e.found || out_data.cell_slot !== e.cell_slot ||
                        out_data.cell_global_id !== e.cell_global_id ||
                        out_data.miss_key !== e.miss_key)
                    begin
                        $display("%0t: expected found=%0d slot=%0d id=%0h key=%0h",
                                 $time, e.found, e.cell_slot, e.cell_global_id, e.miss_key);
                        $display("%0t: actual   found=%0d slot=%0d id=%0h key=%0h",
                                 $time, out_data.found, out_data.cell_slot,
                                 out_data.cell_global_id, out_data.miss_key);
                        fail_count++;
                    end
                end
            end
            waiting = located_q.size();
        end
    end

endmodule

### sim/point_in_tetrahedron_locator_unit_tb.sv
// Testbench top for the tetrahedron locator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module point_in_tetrahedron_locator_unit_tb;
    import pitl_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] ADDR_TOL   = {CFG_REG_TOLERANCE, 3'b000};
    localparam logic [CFG_ADDR_W-1:0] ADDR_COUNT = {CFG_REG_COUNT, 3'b000};
    localparam logic [KEY_W-1:0]      TOL_MAX    = '1;
    localparam int MODE_RANDOM  = 0;
    localparam int MODE_EXTREME = 1;
    localparam int MODE_FLAT    = 2;
    localparam int MODE_TIE_ID  = 3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    waiting;
    bit                    calm;
    int                    stall_hold;
    int                    center_x [1024];
    int                    center_y [1024];
    int                    center_z [1024];

    point_in_tetrahedron_locator_unit dut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    pitl_scoreboard checker_inst
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .waiting(waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL point_in_tetrahedron_locator_unit");
        $finish;
    end

    always @(posedge clk)
    begin
        if (calm)
            out_stall <= 1'b0;
        else if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_hold <= $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic int clamp16(int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    task automatic send(input in_item_t item);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic query(input int qx, input int qy, input int qz);
        in_item_t item;
        item = '0;
        item.cmd = CMD_QUERY;
        item.slot = SLOT_W'($urandom);
        item.corner = CORNER_W'($urandom);
        item.global_id = $urandom;
        item.x = 16'(clamp16(qx));
        item.y = 16'(clamp16(qy));
        item.z = 16'(clamp16(qz));
        send(item);
    endtask

    task automatic load_corner(input int s, input int k, input int px, input int py,
                               input int pz, input logic [ID_W-1:0] id);
        in_item_t item;
        item.cmd = CMD_LOAD;
        item.slot = SLOT_W'(s);
        item.corner = CORNER_W'(k);
        item.x = 16'(clamp16(px));
        item.y = 16'(clamp16(py));
        item.z = 16'(clamp16(pz));
        item.global_id = id;
        send(item);
    endtask

    task automatic load_cell(input int s, input int mode);
        int px [4];
        int py [4];
        int pz [4];
        int cx;
        int cy;
        int cz;
        int r;
        logic [ID_W-1:0] id;
        cx = $urandom_range(0, 60000) - 30000;
        cy = $urandom_range(0, 60000) - 30000;
        cz = $urandom_range(0, 60000) - 30000;
        case ($urandom_range(0, 2))
            0: r = 4;
            1: r = 100;
            default: r = 2000;
        endcase
        id = (mode == MODE_TIE_ID) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
        for (int k = 0; k < 4; k++)
        begin
            if (mode == MODE_EXTREME)
            begin
                px[k] = (k == 1) ? 32767 : -32768;
                py[k] = (k == 2) ? 32767 : -32768;
                pz[k] = (k == 3) ? 32767 : -32768;
            end
            else if (mode == MODE_FLAT)
            begin
                px[k] = cx;
                py[k] = cy;
                pz[k] = cz;
            end
            else
            begin
                px[k] = clamp16(cx + $urandom_range(0, 2 * r) - r);
                py[k] = clamp16(cy + $urandom_range(0, 2 * r) - r);
                pz[k] = clamp16(cz + $urandom_range(0, 2 * r) - r);
            end
        end
        center_x[s] = (px[0] + px[1] + px[2] + px[3]) / 4;
        center_y[s] = (py[0] + py[1] + py[2] + py[3]) / 4;
        center_z[s] = (pz[0] + pz[1] + pz[2] + pz[3]) / 4;
        // Every corner load rewrites the id; only the last one sticks.
        for (int k = 0; k < 4; k++)
            load_corner(s, k, px[k], py[k], pz[k], (k == 3) ? id : ID_W'($urandom));
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Trailing loads give no result, so allow time for them to drain as well.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic target_query(input int lim);
        int c;
        int j;
        c = $urandom_range(0, lim - 1);
        j = $urandom_range(0, 3);
        query(center_x[c] + $urandom_range(0, 2 * j) - j,
              center_y[c] + $urandom_range(0, 2 * j) - j,
              center_z[c] + $urandom_range(0, 2 * j) - j);
    endtask

    task automatic random_phase(input logic [KEY_W-1:0] tol, input int cnt, input int n);
        int lim;
        int pick;
        lim = (cnt > 1024) ? 1024 : cnt;
        cfg_write(ADDR_TOL, CFG_DATA_W'(tol));
        cfg_write(ADDR_COUNT, CFG_DATA_W'(cnt));
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 4)
                target_query(lim);
            else if (pick == 5)
                query($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                      $urandom_range(0, 65535) - 32768);
            else if (pick == 6)
                query($urandom_range(0, 1) ? 32767 : -32768,
                      $urandom_range(0, 1) ? 32767 : -32768,
                      $urandom_range(0, 1) ? 32767 : -32768);
            else if (pick <= 8)
                load_cell($urandom_range(0, lim - 1), $urandom_range(0, 9) == 0 ?
                          MODE_TIE_ID : MODE_RANDOM);
            else
                load_corner($urandom_range(0, 1023), $urandom_range(0, 3),
                            $urandom_range(0, 65535) - 32768,
                            $urandom_range(0, 65535) - 32768,
                            $urandom_range(0, 65535) - 32768, ID_W'($urandom));
        end
        settle();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        out_stall <= 1'b0;
        stall_hold = 0;
        calm = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An empty table finds nothing.
        cfg_write(ADDR_TOL, '0);
        cfg_write(ADDR_COUNT, '0);
        query(0, 0, 0);
        query(32767, -32768, 32767);
        settle();

        // Fill every slot that a later query scans before any query reads it.
        load_cell(0, MODE_EXTREME);
        load_cell(1, MODE_FLAT);
        load_cell(2, MODE_TIE_ID);
        load_cell(3, MODE_TIE_ID);
        for (int s = 4; s < 32; s++)
            load_cell(s, (s % 8 == 0) ? MODE_TIE_ID : MODE_RANDOM);
        settle();

        cfg_write(ADDR_COUNT, CFG_DATA_W'(4));
        for (int c = 0; c < 4; c++)
            query(center_x[c], center_y[c], center_z[c]);
        query(32767, 32767, 32767);
        query(-32768, -32768, -32768);
        query(0, 0, 0);
        load_cell(2, MODE_TIE_ID);
        load_cell(2, MODE_RANDOM);
        query(center_x[2], center_y[2], center_z[2]);
        settle();
        cfg_write(ADDR_TOL, CFG_DATA_W'(TOL_MAX));
        query(32767, -32768, 0);
        query(center_x[3], center_y[3], center_z[3]);
        settle();

        random_phase('0, 8, 50);
        random_phase(KEY_W'(5000), 16, 50);
        random_phase(TOL_MAX, 6, 40);
        random_phase(KEY_W'(123456789), 32, 50);
        random_phase('0, 1, 30);
        calm = 1'b1;
        random_phase(KEY_W'($urandom), 3, 40);

        if (fail_count == 0 && waiting == 0)
            $display("PASS point_in_tetrahedron_locator_unit");
        else
            $display("FAIL point_in_tetrahedron_locator_unit");
        $finish;
    end

endmodule

### files.f
rtl/pitl_pkg.sv
rtl/pitl_front.sv
rtl/pitl_back.sv
rtl/point_in_tetrahedron_locator_unit.sv
rtl/pitl_checker.sv
sim/pitl_scoreboard.sv
sim/point_in_tetrahedron_locator_unit_tb.sv
